// ----- hdl/sha256_stream_hash_unit_assert.svh -----
// Assertion macros shared by the checker of the streaming hash unit.
// Both macros expect a clock named clk and a reset named rst in scope.
`ifndef SHA256_STREAM_HASH_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASH_UNIT_ASSERT_SVH
// Same-cycle implication.
`define SHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/shs_pkg.sv -----
// Constants and round functions for the streaming SHA-256 unit.
// No dependencies.
package shs_pkg;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [2:0] MAX_BYTES = 3'd4;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- hdl/shs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module shs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sha256_stream_hash_unit.sv -----
// Streaming SHA-256 engine: byte packer, block RAM, round datapath.
// Uses shs_pkg and shs_ram.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  data     | data_valid data_stall data_word          | in
//           | valid_bytes last_word                    |
//  digest   | digest_valid digest_stall digest_word    | out
//           | word_index digest_last                   |
//
// One item at a time: the word is taken, its valid bytes are packed one
// by one, then a closing step comes before the next transfer is taken.
// A full block is read from the RAM into the schedule window, then runs
// 64 rounds at one per cycle and is folded into the hash.
// A last word adds byte-wise padding (plus a block when the length does
// not fit) and 8 digest transfers. Reset is synchronous.
// The RAM is written in packing and padding; its read data feeds readout.
module sha256_stream_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_last
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_BYTES = 7'b0000010,
    ST_PAD   = 7'b0000100,
    ST_LOAD  = 7'b0001000,
    ST_COMP  = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t      state;
  logic        ret_pad;
  logic        final_blk;
  logic        pad_first;
  logic        last_q;
  logic [2:0]  cnt;
  logic [31:0] data_sh;
  logic [5:0]  fill;
  logic [60:0] byte_count;
  logic [31:0] acc;
  logic [4:0]  ld;
  logic [5:0]  rnd;
  logic [2:0]  oidx;
  logic [31:0] hash [8];
  logic [31:0] v    [8];
  logic [31:0] w    [16];

  // byte packer
  logic        put_en;
  logic [7:0]  put_b;
  logic [31:0] acc_new;
  logic [5:0]  fill_inc;
  logic [31:0] rdata;
  logic [3:0]  ld_idx;
  logic [31:0] ld_word;
  logic [31:0] t1, t2, w_new;

  assign put_en   = ((state == ST_BYTES) && (cnt != 3'd0)) || (state == ST_PAD);
  assign put_b    = (state == ST_BYTES) ? data_sh[31:24] :
                    (pad_first ? shs_pkg::PAD_MARK : 8'h00);
  assign fill_inc = fill + 6'd1;

  always_comb begin
    acc_new = acc;
    unique case (fill[1:0])
      2'd0: acc_new[31:24] = put_b;
      2'd1: acc_new[23:16] = put_b;
      2'd2: acc_new[15:8]  = put_b;
      2'd3: acc_new[7:0]   = put_b;
    endcase
  end

  shs_ram #(.WIDTH(32), .DEPTH(16)) u_block (
    .clk   (clk),
    .we    (put_en && (fill[1:0] == 2'd3)),
    .waddr (fill[5:2]),
    .wdata (acc_new),
    .raddr (ld[3:0]),
    .rdata (rdata)
  );

  // readout word, length words replace the last two on the final block
  assign ld_idx = ld[3:0] - 4'd1;
  always_comb begin
    ld_word = rdata;
    if (final_blk && (ld_idx == 4'd14)) begin
      ld_word = byte_count[60:29];
    end else if (final_blk && (ld_idx == 4'd15)) begin
      ld_word = {byte_count[28:0], 3'b000};
    end
  end

  // round datapath
  assign t1 = v[7] + shs_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + shs_pkg::ROUND_K[rnd] + w[0];
  assign t2 = shs_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign w_new = shs_pkg::ssig1(w[14]) + w[9] + shs_pkg::ssig0(w[1]) + w[0];

  // handshakes
  assign data_stall   = (state != ST_IDLE);
  assign digest_valid = (state == ST_OUT);
  assign digest_word  = hash[oidx];
  assign word_index   = oidx;
  assign digest_last  = (oidx == 3'd7);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret_pad    <= 1'b0;
      final_blk  <= 1'b0;
      pad_first  <= 1'b0;
      cnt        <= 3'd0;
      fill       <= 6'd0;
      byte_count <= 61'd0;
      ld         <= 5'd0;
      rnd        <= 6'd0;
      oidx       <= 3'd0;
      for (int j = 0; j < 8; j++) begin
        hash[j] <= shs_pkg::H_INIT[j];
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (data_valid) begin
            data_sh <= data_word;
            cnt     <= (valid_bytes > shs_pkg::MAX_BYTES) ? shs_pkg::MAX_BYTES
                                                          : valid_bytes;
            last_q  <= last_word;
            state   <= ST_BYTES;
          end
        end
        ST_BYTES: begin
          if (cnt == 3'd0) begin
            if (last_q) begin
              pad_first <= 1'b1;
              state     <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            data_sh    <= {data_sh[23:0], 8'h00};
            cnt        <= cnt - 3'd1;
            byte_count <= byte_count + 61'd1;
            acc        <= acc_new;
            fill       <= fill_inc;
            if (fill == 6'd63) begin
              ret_pad <= 1'b0;
              ld      <= 5'd0;
              state   <= ST_LOAD;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          acc       <= acc_new;
          fill      <= fill_inc;
          if (fill == 6'd63) begin
            ret_pad <= 1'b1;
            ld      <= 5'd0;
            state   <= ST_LOAD;
          end else if (fill_inc == shs_pkg::LEN_POS) begin
            final_blk <= 1'b1;
            ld        <= 5'd0;
            state     <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          ld <= ld + 5'd1;
          if (ld != 5'd0) begin
            for (int j = 0; j < 15; j++) begin
              w[j] <= w[j+1];
            end
            w[15] <= ld_word;
          end
          if (ld == 5'd16) begin
            rnd <= 6'd0;
            for (int j = 0; j < 8; j++) begin
              v[j] <= hash[j];
            end
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          for (int j = 1; j < 8; j++) begin
            v[j] <= v[j-1];
          end
          v[4] <= v[3] + t1;
          v[0] <= t1 + t2;
          for (int j = 0; j < 15; j++) begin
            w[j] <= w[j+1];
          end
          w[15] <= w_new;
          rnd   <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          for (int j = 0; j < 8; j++) begin
            hash[j] <= hash[j] + v[j];
          end
          if (final_blk) begin
            oidx  <= 3'd0;
            state <= ST_OUT;
          end else begin
            state <= ret_pad ? ST_PAD : ST_BYTES;
          end
        end
        ST_OUT: begin
          if (!digest_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int j = 0; j < 8; j++) begin
                hash[j] <= shs_pkg::H_INIT[j];
              end
              byte_count <= 61'd0;
              fill       <= 6'd0;
              final_blk  <= 1'b0;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/shs_checker.sv -----
// Port-level checks for the streaming hash unit, bound to its top level.
// Uses the macros in sha256_stream_hash_unit_assert.svh.
`include "sha256_stream_hash_unit_assert.svh"
module shs_checker (
  input logic        clk,
  input logic        rst,
  input logic        data_valid,
  input logic        data_stall,
  input logic        digest_valid,
  input logic        digest_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        digest_last
);

  // a stalled digest word holds
  `SHS_ASSERT_NEXT(a_out_hold, digest_valid && digest_stall, digest_valid && $stable(digest_word) && $stable(word_index), "digest word changed under stall")
  // the eight words come in order with no gap
  `SHS_ASSERT_NEXT(a_out_seq, digest_valid && !digest_stall && !digest_last, digest_valid && (word_index == $past(word_index) + 3'd1), "digest sequence broken")
  // last flag marks the eighth word
  `SHS_ASSERT_NOW(a_last_idx, digest_valid, digest_last == (word_index == 3'd7), "last flag off index")
  // no new input while a digest is out, busy right after a transfer
  `SHS_ASSERT_NOW(a_busy_out, digest_valid, data_stall, "input taken during digest")
  `SHS_ASSERT_NEXT(a_busy_in, data_valid && !data_stall, data_stall, "input taken back to back")

endmodule

bind sha256_stream_hash_unit shs_checker u_shs_checker (.*);
